// ===== rtl/utf8_text_paginator_macros.svh =====
// Assertion helpers for the paginator top level.
`ifndef UTF8_TEXT_PAGINATOR_MACROS_SVH
`define UTF8_TEXT_PAGINATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("paginator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("paginator check failed");

`endif

// ===== rtl/utp_pkg.sv =====
`default_nettype none

package utp_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LIMIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_LIMIT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NARROW_WIDTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_HEIGHT  = 3'd4;

    // Register reset values
    localparam logic [10:0] LINE_LIMIT_RST   = 11'd296;
    localparam logic [10:0] PAGE_LIMIT_RST   = 11'd128;
    localparam logic [7:0]  NARROW_WIDTH_RST = 8'd8;
    localparam logic [7:0]  WIDE_WIDTH_RST   = 8'd16;
    localparam logic [7:0]  LINE_HEIGHT_RST  = 8'd16;

    // Character codes and lengths
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [2:0] LEN_ONE      = 3'd1;
    localparam logic [2:0] LEN_TWO      = 3'd2;
    localparam logic [2:0] LEN_THREE    = 3'd3;
    localparam logic [2:0] LEN_FOUR     = 3'd4;

    localparam logic [15:0] BYTES_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [23:0] page_number;
        logic [31:0] page_offset;
        logic [15:0] page_bytes;
        logic        bad_utf8;
    } out_t;

    typedef struct packed {
        logic [10:0] line_limit;
        logic [10:0] page_limit;
        logic [7:0]  narrow_width;
        logic [7:0]  wide_width;
        logic [7:0]  line_height;
    } cfg_t;

    typedef struct packed {
        logic halted;
        logic mid_char;
    } core_status_t;

endpackage

`default_nettype wire

// ===== rtl/utp_lead_decode.sv =====
`default_nettype none

module utp_lead_decode
    import utp_pkg::*;
(
    input  wire logic [7:0] lead_byte,
    output logic [2:0]      char_len,
    output logic            bad_lead
);

    // Classify the lead byte by its high bits
    always_comb
    begin
        char_len = LEN_ONE;
        bad_lead = 1'b0;
        case (lead_byte) inside
            8'b0???????: char_len = LEN_ONE;
            8'b110?????: char_len = LEN_TWO;
            8'b1110????: char_len = LEN_THREE;
            8'b11110???: char_len = LEN_FOUR;
            default:
            begin
                char_len = 3'd0;
                bad_lead = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/utp_page_core.sv =====
`default_nettype none

module utp_page_core
    import utp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   fire,
    input  wire in_t    item,
    input  wire cfg_t   cfg,
    output logic        res_valid,
    output out_t        res,
    output core_status_t status
);

    logic [31:0] byte_pos_reg,    byte_pos_next;
    logic [31:0] page_start_reg,  page_start_next;
    logic [23:0] page_cnt_reg,    page_cnt_next;
    logic [15:0] page_bytes_reg,  page_bytes_next;
    logic [10:0] line_fill_reg,   line_fill_next;
    logic [11:0] line_top_reg,    line_top_next;
    logic [2:0]  char_len_reg,    char_len_next;
    logic [1:0]  bytes_left_reg,  bytes_left_next;
    logic        halted_reg,      halted_next;

    logic [2:0]  dec_len;
    logic        dec_bad;

    // Placement datapath
    logic [2:0]  place_len;
    logic [7:0]  char_w;
    logic        is_nl;
    logic [11:0] fill_sum;
    logic        line_over;
    logic        line_brk;
    logic [11:0] top_sum;
    logic [12:0] page_chk;
    logic        page_brk;
    logic [2:0]  add_amt;
    logic [15:0] bytes_add;
    logic [31:0] pos_inc;
    logic [15:0] bytes_end;
    logic        do_place;

    function automatic logic [15:0] sat_add(input logic [15:0] base, input logic [2:0] amt);
        logic [16:0] sum;
        sum = {1'b0, base} + {14'd0, amt};
        return sum[16] ? BYTES_MAX : sum[15:0];
    endfunction

    utp_lead_decode u_decode (
        .lead_byte (item.text_byte),
        .char_len  (dec_len),
        .bad_lead  (dec_bad)
    );

    assign status.halted   = halted_reg;
    assign status.mid_char = (bytes_left_reg != 2'd0);

    // Line and page fit for the character being completed
    always_comb
    begin
        place_len = (bytes_left_reg != 2'd0) ? char_len_reg : LEN_ONE;
        char_w    = (place_len == LEN_ONE) ? cfg.narrow_width : cfg.wide_width;
        is_nl     = (place_len == LEN_ONE) && (item.text_byte == NEWLINE_CHAR);
        fill_sum  = {1'b0, line_fill_reg} + {4'd0, char_w};
        line_over = fill_sum > {1'b0, cfg.line_limit};
        line_brk  = is_nl || line_over;
        top_sum   = line_top_reg + {4'd0, cfg.line_height};
        page_chk  = {1'b0, top_sum} + {5'd0, cfg.line_height};
        page_brk  = line_brk && (page_chk > {2'd0, cfg.page_limit});
        add_amt   = is_nl ? LEN_ONE : place_len;
        bytes_add = sat_add(page_bytes_reg, add_amt);
        pos_inc   = byte_pos_reg + 32'd1;
        bytes_end = (bytes_left_reg != 2'd0)
                  ? sat_add(page_bytes_reg, char_len_reg - {1'b0, bytes_left_reg})
                  : page_bytes_reg;
    end

    // Sequence one beat through the state
    always_comb
    begin
        byte_pos_next   = byte_pos_reg;
        page_start_next = page_start_reg;
        page_cnt_next   = page_cnt_reg;
        page_bytes_next = page_bytes_reg;
        line_fill_next  = line_fill_reg;
        line_top_next   = line_top_reg;
        char_len_next   = char_len_reg;
        bytes_left_next = bytes_left_reg;
        halted_next     = halted_reg;
        res_valid       = 1'b0;
        res             = '0;
        do_place        = 1'b0;

        if (fire)
        begin
            if (item.end_of_text)
            begin
                // Flush the last page and restart
                if (!halted_reg && (bytes_end != 16'd0))
                begin
                    res_valid        = 1'b1;
                    res.page_number  = page_cnt_reg;
                    res.page_offset  = page_start_reg;
                    res.page_bytes   = bytes_end;
                end
                byte_pos_next   = '0;
                page_start_next = '0;
                page_cnt_next   = 24'd1;
                page_bytes_next = '0;
                line_fill_next  = '0;
                line_top_next   = '0;
                char_len_next   = '0;
                bytes_left_next = '0;
                halted_next     = 1'b0;
            end
            else if (!halted_reg)
            begin
                byte_pos_next = pos_inc;
                if (bytes_left_reg != 2'd0)
                begin
                    bytes_left_next = bytes_left_reg - 2'd1;
                    do_place        = (bytes_left_reg == 2'd1);
                end
                else if (dec_bad)
                begin
                    res_valid     = 1'b1;
                    res.bad_utf8  = 1'b1;
                    halted_next   = 1'b1;
                    char_len_next = '0;
                end
                else
                begin
                    char_len_next = dec_len;
                    if (dec_len == LEN_ONE)
                        do_place = 1'b1;
                    else
                        bytes_left_next = 2'(dec_len - LEN_ONE);
                end
            end
        end

        // Commit the placement of a finished character
        if (do_place)
        begin
            if (line_brk)
            begin
                line_fill_next = is_nl ? 11'd0 : {3'd0, char_w};
                if (page_brk)
                begin
                    res_valid       = 1'b1;
                    res.page_number = page_cnt_reg;
                    res.page_offset = page_start_reg;
                    res.page_bytes  = is_nl ? bytes_add : page_bytes_reg;
                    page_start_next = is_nl ? pos_inc : pos_inc - {29'd0, place_len};
                    page_bytes_next = is_nl ? 16'd0 : {13'd0, place_len};
                    line_top_next   = '0;
                    page_cnt_next   = page_cnt_reg + 24'd1;
                end
                else
                begin
                    page_bytes_next = bytes_add;
                    line_top_next   = top_sum;
                end
            end
            else
            begin
                line_fill_next  = fill_sum[10:0];
                page_bytes_next = bytes_add;
            end
        end
    end

    // Hold text state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            page_start_reg <= '0;
            page_cnt_reg   <= 24'd1;
            page_bytes_reg <= '0;
            line_fill_reg  <= '0;
            line_top_reg   <= '0;
            char_len_reg   <= '0;
            bytes_left_reg <= '0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            byte_pos_reg   <= byte_pos_next;
            page_start_reg <= page_start_next;
            page_cnt_reg   <= page_cnt_next;
            page_bytes_reg <= page_bytes_next;
            line_fill_reg  <= line_fill_next;
            line_top_reg   <= line_top_next;
            char_len_reg   <= char_len_next;
            bytes_left_reg <= bytes_left_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8_text_paginator.sv =====
// UTF-8 text paginator.
// Input channel in_valid/in_stall/in_data carries one text byte per beat, or
// an end-of-text beat (end_of_text = 1) that flushes the last page and
// restarts for a new text. Output channel out_valid/out_stall/out_data
// carries page records (number, start offset, byte count) or a bad-lead
// record (bad_utf8 = 1, other fields zero). After a bad lead byte all bytes
// are dropped until the end beat, which then produces nothing.
// Throughput: one input beat per cycle while out_stall does not hold a record.
// Each beat is captured in an input register; when it advances, a single
// pass of decode, line-fit and page-fit logic updates the text state and
// loads the output register, which drives out_valid when a record results.
// Beats that produce no record still take one pass.
// Configuration: cfg_write/cfg_index/cfg_data write one register per cycle;
// indexes beyond the register list are dropped. Write only while idle.
// Reset: rst_n clears the text state, the pipeline and the registers to
// their defaults; no clearing pass is needed.
// Stall: while out_stall holds a waiting record, the input register can hold
// one more beat; after that in_stall rises until the record is taken.
`default_nettype none

`include "utf8_text_paginator_macros.svh"

module utf8_text_paginator
    import utp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_t                    in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_t                        out_data,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t         cfg_reg;
    logic         s1_valid_reg, s1_valid_next;
    in_t          s1_item_reg;
    logic         out_valid_reg, out_valid_next;
    out_t         out_data_reg;
    logic         out_free;
    logic         s1_advance;
    logic         in_accept;
    logic         res_valid;
    out_t         res;
    core_status_t core_status;

    // Handshake control
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance && res_valid)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
    end

    utp_page_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_advance),
        .item      (s1_item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res),
        .status    (core_status)
    );

    // Hold pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payload beats
    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_item_reg <= in_data;
        if (s1_advance && res_valid)
            out_data_reg <= res;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_limit   <= LINE_LIMIT_RST;
            cfg_reg.page_limit   <= PAGE_LIMIT_RST;
            cfg_reg.narrow_width <= NARROW_WIDTH_RST;
            cfg_reg.wide_width   <= WIDE_WIDTH_RST;
            cfg_reg.line_height  <= LINE_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LINE_LIMIT:   cfg_reg.line_limit   <= cfg_data;
                CFG_PAGE_LIMIT:   cfg_reg.page_limit   <= cfg_data;
                CFG_NARROW_WIDTH: cfg_reg.narrow_width <= cfg_data[7:0];
                CFG_WIDE_WIDTH:   cfg_reg.wide_width   <= cfg_data[7:0];
                CFG_LINE_HEIGHT:  cfg_reg.line_height  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Checks
    `UTP_ASSERT_IMP(a_bad_fields_zero, clk, rst_n, out_valid && out_data.bad_utf8, (out_data.page_number == 24'd0) && (out_data.page_offset == 32'd0) && (out_data.page_bytes == 16'd0))
    `UTP_ASSERT_NXT(a_bad_halts, clk, rst_n, s1_advance && res_valid && res.bad_utf8, core_status.halted)
    `UTP_ASSERT_IMP(a_halted_quiet, clk, rst_n, s1_advance && core_status.halted && !s1_item_reg.end_of_text, !res_valid)
    `UTP_ASSERT_IMP(a_halt_no_char, clk, rst_n, core_status.halted, !core_status.mid_char)
    `UTP_ASSERT_IMP(a_stall_needs_item, clk, rst_n, !s1_valid_reg, !in_stall)
    `UTP_ASSERT_NXT(a_result_kept, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

`default_nettype wire
